// File: rtl/core/btsd_pkg.sv
// Shared types and constants for the bit tree string decoder.
package btsd_pkg;

	localparam int TableEntries = 256;
	localparam int TableAw      = $clog2(TableEntries);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} state_t;

	localparam logic [1:0] KIND_PLAIN = 2'd0;
	localparam logic [1:0] KIND_EXT   = 2'd1;
	localparam logic [1:0] KIND_DICT  = 2'd2;
	localparam logic [1:0] KIND_END   = 2'd3;

	localparam logic [1:0] REG_NEW_FORMAT  = 2'd0;
	localparam logic [1:0] REG_ESCAPE_BITS = 2'd1;
	localparam logic [1:0] REG_BOUNDARY    = 2'd2;

	localparam logic [7:0] ENTRY_END    = 8'h80;
	localparam logic [7:0] ENTRY_NODE   = 8'h81;
	localparam logic [7:0] ENTRY_ESCAPE = 8'h5f;

	localparam logic [4:0] ESC_LEN_MAX = 5'd16;

	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic [15:0] value;
	} symbol_t;

endpackage

// File: rtl/core/bit_tree_string_decoder_core.sv
// Bit tree string decoder: table memory, bit walker, escape collector and APB registers.
// A load word (mode 0) writes one table entry and busy stays low.
// A decode word (mode 1) holds busy while it walks b bits (1..8), one bit per cycle as set by
// the dependent table read, and then through a flush state; a new word waits for busy to fall.
// Results trail the walk by one symbol; the final one, flagged last, follows busy falling.
// Reset clears node and escape state and sets the registers to 1, 7, 0; the table is
// undefined until written and needs no clearing pass. Results are never stalled.
module bit_tree_string_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [7:0]  table_index,
	input  logic [7:0]  table_value,
	input  logic [7:0]  stream_byte,
	output logic        strobe,
	output logic [1:0]  symbol_kind,
	output logic [15:0] symbol_value,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import btsd_pkg::*;

	logic [7:0] tab_mem [TableEntries];

	state_t      state_q, state_n;
	logic        accept, run, flush;
	logic        cfg_wr;
	logic [1:0]  cfg_idx;

	logic        new_fmt_q;
	logic [4:0]  esc_bits_q;
	logic [6:0]  boundary_q;

	logic [7:0]  byte_q;
	logic [2:0]  bit_q;
	logic [6:0]  node_q, node_n;
	logic        esc_q, esc_n;
	logic [4:0]  cnt_q, cnt_n;
	logic [15:0] acc_q, acc_n;

	logic [7:0]  rd_idx;
	logic [7:0]  rd_data_s1;
	logic        oob_s1;

	logic        cur_bit, stop, fin_esc;
	logic [7:0]  entry;
	logic [4:0]  esc_len;
	logic [15:0] code;
	symbol_t     sym, pend_q;

	logic        strobe_q, last_q;
	logic [1:0]  kind_q;
	logic [15:0] value_q;

	assign accept  = start && !busy;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// configuration registers
	assign pready = 1'b1;

	always_comb begin
		unique case (cfg_idx)
			REG_NEW_FORMAT:  prdata = {31'd0, new_fmt_q};
			REG_ESCAPE_BITS: prdata = {27'd0, esc_bits_q};
			REG_BOUNDARY:    prdata = {25'd0, boundary_q};
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			new_fmt_q  <= 1'b1;
			esc_bits_q <= 5'd7;
			boundary_q <= 7'd0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_NEW_FORMAT:  new_fmt_q  <= pwdata[0];
				REG_ESCAPE_BITS: esc_bits_q <= pwdata[4:0];
				REG_BOUNDARY:    boundary_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept && mode) state_n = ST_RUN;
			ST_RUN:   if (stop || bit_q == 3'd0) state_n = ST_FLUSH;
			ST_FLUSH: state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy  = (state_q != ST_IDLE);
		run   = (state_q == ST_RUN);
		flush = (state_q == ST_FLUSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_n;
	end

	// one tree step per cycle on the entry read for the current bit
	always_comb begin
		cur_bit = byte_q[bit_q];
		entry   = oob_s1 ? ENTRY_END : rd_data_s1;
		esc_len = (esc_bits_q > ESC_LEN_MAX) ? ESC_LEN_MAX : esc_bits_q;
		node_n  = node_q;
		esc_n   = esc_q;
		cnt_n   = cnt_q;
		acc_n   = acc_q;
		stop    = 1'b0;
		fin_esc = 1'b0;
		code    = '0;
		sym     = '{valid: 1'b0, kind: KIND_PLAIN, value: 16'd0};
		if (esc_q) begin
			acc_n = {acc_q[14:0], cur_bit};
			cnt_n = cnt_q + 5'd1;
			if (cnt_n >= esc_len) begin
				fin_esc = 1'b1;
				code    = acc_n;
			end
		end else if (entry >= ENTRY_NODE) begin
			node_n = entry[6:0];
		end else if (entry == ENTRY_END) begin
			sym    = '{valid: 1'b1, kind: KIND_END, value: 16'd0};
			node_n = '0;
			esc_n  = 1'b0;
			cnt_n  = '0;
			acc_n  = '0;
			stop   = 1'b1;
		end else if (entry == ENTRY_ESCAPE) begin
			cnt_n = '0;
			acc_n = '0;
			if (esc_len == 5'd0) begin
				fin_esc = 1'b1;
			end else begin
				esc_n  = 1'b1;
				node_n = '0;
			end
		end else begin
			sym    = '{valid: 1'b1, kind: KIND_PLAIN, value: {8'd0, entry} + 16'h0020};
			node_n = '0;
		end
		if (fin_esc) begin
			esc_n  = 1'b0;
			cnt_n  = '0;
			acc_n  = '0;
			node_n = '0;
			priority if (!new_fmt_q)
				sym = '{valid: 1'b1, kind: KIND_EXT, value: code + 16'h0080};
			else if (code < {9'd0, boundary_q})
				sym = '{valid: 1'b1, kind: KIND_EXT, value: code + 16'h00a0};
			else
				sym = '{valid: 1'b1, kind: KIND_DICT, value: code - {9'd0, boundary_q}};
		end
	end

	// address of the entry for the next bit
	assign rd_idx = run ? {node_n, byte_q[bit_q - 3'd1]} : {node_q, stream_byte[7]};

	always_ff @(posedge clk) begin
		if (accept && !mode && ({1'b0, table_index} < 9'(TableEntries)))
			tab_mem[table_index[TableAw-1:0]] <= table_value;
		rd_data_s1 <= tab_mem[rd_idx[TableAw-1:0]];
		oob_s1     <= ({1'b0, rd_idx} >= 9'(TableEntries));
	end

	always_ff @(posedge clk) begin
		if (accept && mode) byte_q <= stream_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q  <= '0;
			node_q <= '0;
			esc_q  <= 1'b0;
			cnt_q  <= '0;
			acc_q  <= '0;
		end else if (accept && mode) begin
			bit_q <= 3'd7;
		end else if (run) begin
			bit_q  <= bit_q - 3'd1;
			node_q <= node_n;
			esc_q  <= esc_n;
			cnt_q  <= cnt_n;
			acc_q  <= acc_n;
		end
	end

	// hold one symbol back so the final one of the word can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			kind_q   <= KIND_PLAIN;
			value_q  <= '0;
		end else begin
			strobe_q <= ((run && sym.valid) || flush) && pend_q.valid;
			last_q   <= flush && pend_q.valid;
			if ((run && sym.valid) || flush) begin
				kind_q  <= pend_q.kind;
				value_q <= pend_q.value;
			end
			if (run && sym.valid)
				pend_q <= sym;
			else if (flush)
				pend_q.valid <= 1'b0;
		end
	end

	assign strobe       = strobe_q;
	assign last         = last_q;
	assign symbol_kind  = kind_q;
	assign symbol_value = value_q;

	a_strobe_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result without a decode word in flight");

	a_last_ends_word: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("last result before the word finished");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("result straight after last");

	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !pend_q.valid)
		else $error("held symbol left behind at idle");

	a_esc_count: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> cnt_q < ESC_LEN_MAX)
		else $error("escape count out of range");

endmodule
